>>> hdl/qse_pkg.sv
// qse_pkg: shared types and constants for the quoted string escape encoder
// no dependencies; imported by the encoder and the top level
package qse_pkg;

  localparam int RunMax = 6;
  localparam int LenW   = 3;

  // input command codes
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // character codes
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [4:0] OCT_HEAD  = 5'b00110;  // '0' with the low three bits clear

  typedef logic [LenW-1:0] run_len_t;

  // one encoded run: the bytes caused by one input item
  typedef struct packed {
    logic [RunMax-1:0][7:0] bytes;
    run_len_t               len;
    logic                   done;   // run ends in the closing quote
  } qse_run_t;

endpackage

>>> hdl/qse_if.sv
// qse_in_if / qse_out_if: valid/ready channels for string bytes and encoded text
// no dependencies; payload widths are fixed
interface qse_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface qse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       string_done;

  modport source (output valid, output out_byte, output run_last, output string_done,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input string_done,
                  output ready);
endinterface

>>> hdl/qse_encode.sv
// qse_encode: turns one registered input item into a run of up to six text bytes
// depends on qse_pkg
module qse_encode (
  input  logic              command,
  input  logic [7:0]        data_byte,
  input  logic              string_open,
  input  logic              escape_nonprint,
  output qse_pkg::qse_run_t run,
  output logic              string_open_nxt
);
  import qse_pkg::*;

  logic [4:0][7:0] body;
  run_len_t        body_len;
  logic            is_end;
  logic            is_ctl;
  logic            printable;
  logic [7:0]      ctl_letter;

  assign is_end    = (command == CMD_END) || (data_byte == CH_NUL);
  assign printable = (data_byte >= CH_SPACE) && (data_byte <= CH_TILDE);

  always_comb begin
    is_ctl     = 1'b1;
    ctl_letter = 8'h00;
    unique case (data_byte)
      CH_BS:   ctl_letter = "b";
      CH_FF:   ctl_letter = "f";
      CH_NL:   ctl_letter = "n";
      CH_CR:   ctl_letter = "r";
      CH_TAB:  ctl_letter = "t";
      default: is_ctl = 1'b0;
    endcase
  end

  always_comb begin
    body     = '0;
    body_len = 3'd1;
    if (is_end) begin
      body[0]  = CH_QUOTE;
      body_len = 3'd1;
    end else if (is_ctl) begin
      body[0] = CH_BSLASH;
      body[1] = ctl_letter;
      body_len = 3'd2;
      // newline also breaks the literal: quote, newline, quote
      if (data_byte == CH_NL) begin
        body[2]  = CH_QUOTE;
        body[3]  = CH_NL;
        body[4]  = CH_QUOTE;
        body_len = 3'd5;
      end
    end else if (!escape_nonprint || printable) begin
      if ((data_byte == CH_BSLASH) || (data_byte == CH_QUOTE)) begin
        body[0]  = CH_BSLASH;
        body[1]  = data_byte;
        body_len = 3'd2;
      end else begin
        body[0]  = data_byte;
        body_len = 3'd1;
      end
    end else begin
      body[0]  = CH_BSLASH;
      body[1]  = {OCT_HEAD, 1'b0, data_byte[7:6]};
      body[2]  = {OCT_HEAD, data_byte[5:3]};
      body[3]  = {OCT_HEAD, data_byte[2:0]};
      body_len = 3'd4;
    end
  end

  // opening quote goes in front when no string is open
  always_comb begin
    run.done = is_end;
    if (string_open) begin
      run.bytes = {8'h00, body};
      run.len   = body_len;
    end else begin
      run.bytes = {body, CH_QUOTE};
      run.len   = body_len + 3'd1;
    end
  end

  assign string_open_nxt = !is_end;

endmodule

>>> hdl/quoted_string_escape_encoder.sv
// quoted_string_escape_encoder: top level, input register, encoder and run serializer
// depends on qse_pkg, qse_in_if / qse_out_if and qse_encode
//
//  channel  dir  payload                              beat
//  in_ch    in   command, data_byte                   valid & ready
//  out_ch   out  out_byte, run_last, string_done      valid & ready
//  cfg      in   cfg_wdata (escape_nonprint)          cfg_we
//
// an accepted item waits in the input register until the run register frees, then is
// encoded into it; the run leaves one byte per cycle while out_ch.ready is high
// a run is 1 to 6 text bytes, one per text byte the item causes, sent from the run register
// the input register takes the next item while a run still leaves and holds it until the run ends
// an output stall holds the run and, once the input register is full, the input too
// synchronous active-low reset empties both stages, closes the string, sets escaping on
module quoted_string_escape_encoder (
  input  logic            clk,
  input  logic            rst_n,
  qse_in_if.sink          in_ch,
  qse_out_if.source       out_ch,
  input  logic            cfg_we,
  input  logic            cfg_wdata
);
  import qse_pkg::*;

  logic       in_v_r;
  logic       in_cmd_r;
  logic [7:0] in_data_r;
  logic       run_v_r;
  qse_run_t   run_r;
  run_len_t   idx_r;
  logic       open_r;
  logic       esc_r;

  qse_run_t   enc_run;
  logic       open_nxt;
  logic       last_beat;
  logic       run_free;
  logic       load;
  logic       in_take;

  qse_encode u_encode (
    .command         (in_cmd_r),
    .data_byte       (in_data_r),
    .string_open     (open_r),
    .escape_nonprint (esc_r),
    .run             (enc_run),
    .string_open_nxt (open_nxt)
  );

  assign out_ch.valid       = run_v_r;
  assign out_ch.out_byte    = run_r.bytes[idx_r];
  assign out_ch.run_last    = (idx_r == run_r.len - 3'd1);
  assign out_ch.string_done = run_r.done && out_ch.run_last;

  assign last_beat   = run_v_r && out_ch.ready && out_ch.run_last;
  assign run_free    = !run_v_r || last_beat;
  assign load        = in_v_r && run_free;
  assign in_ch.ready = !in_v_r || load;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      run_v_r <= 1'b0;
      idx_r   <= '0;
      open_r  <= 1'b0;
      esc_r   <= 1'b1;
    end else begin
      if (cfg_we) begin
        esc_r <= cfg_wdata;
      end
      if (in_take) begin
        in_v_r <= 1'b1;
      end else if (load) begin
        in_v_r <= 1'b0;
      end
      if (load) begin
        run_v_r <= 1'b1;
        idx_r   <= '0;
        open_r  <= open_nxt;
      end else if (last_beat) begin
        run_v_r <= 1'b0;
        idx_r   <= '0;
      end else if (run_v_r && out_ch.ready) begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_cmd_r  <= in_ch.command;
      in_data_r <= in_ch.data_byte;
    end
    if (load) begin
      run_r <= enc_run;
    end
  end

  a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    run_v_r |-> (idx_r < run_r.len))
    else $error("run index past run length");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    run_v_r |-> ((run_r.len != 3'd0) && (run_r.len <= 3'd6)))
    else $error("run length out of range");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (run_v_r && !out_ch.ready) |=> (run_v_r && $stable(idx_r)))
    else $error("run moved while output stalled");

  a_done_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (load && enc_run.done) |=> !open_r)
    else $error("string left open after closing quote");

  a_no_idle_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !run_v_r) |-> load)
    else $error("encoded item not moved to free run register");

endmodule
